>>> rtl/core/xcfd_pkg.sv
// Shared widths, markers and result codes of the framed block checker.
`default_nettype none

package xcfd_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned INDEX_W  = 11;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned COUNT_W  = 17;

   localparam logic [WORD_W-1:0] BEGIN_MARK = '0;
   localparam logic [WORD_W-1:0] END_MARK   = '1;

   typedef enum logic [STATUS_W-1:0] {
      ST_BUSY      = 3'd0,
      ST_OK        = 3'd1,
      ST_NO_BEGIN  = 3'd2,
      ST_BAD_SUM   = 3'd3,
      ST_NO_END    = 3'd4,
      ST_BAD_COUNT = 3'd5
   } status_type;

endpackage

`default_nettype wire

>>> rtl/core/xor_checked_frame_decoder_unit.sv
// Framed word stream checker with XOR checksum, one word per clock when not stalled.
//
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid, req_stall | req_in_word
//  rsp_    | out       | rsp_valid, rsp_stall | payload_valid, payload_word, word_index,
//          |           |                      | frame_done, status, bit_count
//
//  One item per clock sustained while rsp_ is not stalled; every item gives exactly one result item.
//  An item passes through the input register, then the frame state and result register.
//  Reset is synchronous and returns the checker to waiting for a begin marker.
//  A stall on rsp_ holds the result register and then the input register;
//  req_stall rises only when both are full.
`default_nettype none

module xor_checked_frame_decoder_unit
   import xcfd_pkg::*;
#(
   parameter int unsigned MAX_BITS = 65536
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire  [WORD_W-1:0]   req_in_word,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic                rsp_payload_valid,
   output logic [WORD_W-1:0]   rsp_payload_word,
   output logic [INDEX_W-1:0]  rsp_word_index,
   output logic                rsp_frame_done,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_bit_count
);

   localparam int unsigned BITS_W  = $clog2(MAX_BITS + 1);
   localparam int unsigned WORDS_W = $clog2((MAX_BITS + 31) / 32 + 1);
   localparam logic [WORD_W-1:0] MAX_WORD = WORD_W'(MAX_BITS);

   typedef enum logic [2:0] {
      PH_WAIT,
      PH_HUNT,
      PH_COUNT,
      PH_PAYLOAD,
      PH_CHECK,
      PH_END
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [BITS_W-1:0]    frame_bits_ff, frame_bits_in;
   logic [WORDS_W-1:0]   words_left_ff, words_left_in;
   logic [INDEX_W-1:0]   next_index_ff, next_index_in;
   logic [WORD_W-1:0]    running_xor_ff, running_xor_in;

   logic                 s1_valid_ff;
   logic [WORD_W-1:0]    s1_word_ff;
   logic                 s2_free;
   logic                 s1_fire;
   logic                 req_fire;

   logic                 rsp_valid_ff;
   logic                 rsp_payload_valid_ff, rsp_payload_valid_in;
   logic [WORD_W-1:0]    rsp_payload_word_ff, rsp_payload_word_in;
   logic [INDEX_W-1:0]   rsp_word_index_ff, rsp_word_index_in;
   logic                 rsp_frame_done_ff, rsp_frame_done_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_bit_count_ff, rsp_bit_count_in;

   logic [WORD_W:0]      rounded_bits;

   assign s2_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && s2_free;
   assign req_stall = s1_valid_ff && !s2_free;
   assign req_fire  = req_valid && !req_stall;

   assign rounded_bits = {1'b0, s1_word_ff} + (WORD_W + 1)'(31);

   always_comb begin
      phase_in             = phase_ff;
      frame_bits_in        = frame_bits_ff;
      words_left_in        = words_left_ff;
      next_index_in        = next_index_ff;
      running_xor_in       = running_xor_ff;
      rsp_payload_valid_in = 1'b0;
      rsp_payload_word_in  = '0;
      rsp_word_index_in    = '0;
      rsp_frame_done_in    = 1'b0;
      rsp_status_in        = ST_BUSY;
      rsp_bit_count_in     = '0;
      unique case (phase_ff)
         PH_COUNT: begin
            if (s1_word_ff > MAX_WORD) begin
               phase_in          = PH_HUNT;
               rsp_frame_done_in = 1'b1;
               rsp_status_in     = ST_BAD_COUNT;
            end else begin
               frame_bits_in  = BITS_W'(s1_word_ff);
               words_left_in  = WORDS_W'(rounded_bits >> 5);
               next_index_in  = '0;
               running_xor_in = '0;
               phase_in       = (s1_word_ff == '0) ? PH_CHECK : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            rsp_payload_valid_in = 1'b1;
            rsp_payload_word_in  = s1_word_ff;
            rsp_word_index_in    = next_index_ff;
            running_xor_in       = running_xor_ff ^ s1_word_ff;
            next_index_in        = next_index_ff + INDEX_W'(1);
            words_left_in        = words_left_ff - WORDS_W'(1);
            if (words_left_ff == WORDS_W'(1)) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            if (s1_word_ff != running_xor_ff) begin
               phase_in          = PH_HUNT;
               rsp_frame_done_in = 1'b1;
               rsp_status_in     = ST_BAD_SUM;
            end else begin
               phase_in = PH_END;
            end
         end
         PH_END: begin
            rsp_frame_done_in = 1'b1;
            if (s1_word_ff != END_MARK) begin
               phase_in      = PH_HUNT;
               rsp_status_in = ST_NO_END;
            end else begin
               phase_in         = PH_WAIT;
               rsp_status_in    = ST_OK;
               rsp_bit_count_in = COUNT_W'(frame_bits_ff);
            end
         end
         PH_HUNT: begin
            if (s1_word_ff == BEGIN_MARK) begin
               phase_in = PH_COUNT;
            end
         end
         default: begin
            if (s1_word_ff == BEGIN_MARK) begin
               phase_in = PH_COUNT;
            end else begin
               phase_in          = PH_HUNT;
               rsp_frame_done_in = 1'b1;
               rsp_status_in     = ST_NO_BEGIN;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         s1_word_ff <= req_in_word;
      end
      if (s1_fire) begin
         frame_bits_ff        <= frame_bits_in;
         words_left_ff        <= words_left_in;
         next_index_ff        <= next_index_in;
         running_xor_ff       <= running_xor_in;
         rsp_payload_valid_ff <= rsp_payload_valid_in;
         rsp_payload_word_ff  <= rsp_payload_word_in;
         rsp_word_index_ff    <= rsp_word_index_in;
         rsp_frame_done_ff    <= rsp_frame_done_in;
         rsp_status_ff        <= rsp_status_in;
         rsp_bit_count_ff     <= rsp_bit_count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload_valid = rsp_payload_valid_ff;
   assign rsp_payload_word  = rsp_payload_word_ff;
   assign rsp_word_index    = rsp_word_index_ff;
   assign rsp_frame_done    = rsp_frame_done_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_bit_count     = rsp_bit_count_ff;

   a_payload_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_valid_ff |-> !rsp_frame_done_ff)
      else $error("payload item marked as frame end");

   a_done_has_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_frame_done_ff == (rsp_status_ff != ST_BUSY)))
      else $error("frame end and status disagree");

   a_count_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bit_count_ff != '0 |-> rsp_status_ff == ST_OK)
      else $error("bit count shown on a frame that did not pass");

   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> words_left_ff != '0)
      else $error("payload phase with no words left");

   a_ok_goes_wait: assert property (@(posedge clock) disable iff (reset)
      s1_fire && rsp_status_in == ST_OK |=> phase_ff == PH_WAIT)
      else $error("good frame did not return to waiting");

endmodule

`default_nettype wire

>>> verif/frame_result_checker.sv
// Frame checker scoreboard: predicts each result item from accepted words and compares.
`timescale 1ns / 100ps

module frame_result_checker
   import xcfd_pkg::*;
#(
   parameter int unsigned MAX_BITS = 65536
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  wire                 req_stall,
   input  wire  [WORD_W-1:0]   req_in_word,
   input  wire                 rsp_valid,
   input  wire                 rsp_stall,
   input  wire                 rsp_payload_valid,
   input  wire  [WORD_W-1:0]   rsp_payload_word,
   input  wire  [INDEX_W-1:0]  rsp_word_index,
   input  wire                 rsp_frame_done,
   input  wire  [STATUS_W-1:0] rsp_status,
   input  wire  [COUNT_W-1:0]  rsp_bit_count,
   output int                  fail_count,
   output int                  pending
);

   typedef enum logic [2:0] {
      WAIT_BEGIN,
      HUNT_BEGIN,
      TAKE_COUNT,
      TAKE_PAYLOAD,
      TAKE_SUM,
      TAKE_END
   } frame_phase_type;

   typedef struct {
      logic                payload_valid;
      logic [WORD_W-1:0]   payload_word;
      logic [INDEX_W-1:0]  word_index;
      logic                frame_done;
      status_type          status;
      logic [COUNT_W-1:0]  bit_count;
   } frame_result_type;

   frame_phase_type     phase;
   logic [COUNT_W-1:0]  frame_bits;
   logic [11:0]         words_left;
   logic [INDEX_W-1:0]  next_index;
   logic [WORD_W-1:0]   running_xor;
   frame_result_type    expected_results[$];
   int                  mismatches = 0;

   assign fail_count = mismatches;

   function automatic frame_result_type decode_frame_word(input logic [WORD_W-1:0] w);
      frame_result_type r;
      r.payload_valid = 1'b0;
      r.payload_word  = '0;
      r.word_index    = '0;
      r.frame_done    = 1'b0;
      r.status        = ST_BUSY;
      r.bit_count     = '0;
      case (phase)
         TAKE_COUNT: begin
            if (w[WORD_W-1] || w > MAX_BITS) begin
               phase = HUNT_BEGIN;
               r.frame_done = 1'b1;
               r.status = ST_BAD_COUNT;
            end else begin
               frame_bits  = COUNT_W'(w);
               words_left  = 12'((w + 31) >> 5);
               next_index  = '0;
               running_xor = '0;
               phase = (words_left == 0) ? TAKE_SUM : TAKE_PAYLOAD;
            end
         end
         TAKE_PAYLOAD: begin
            r.payload_valid = 1'b1;
            r.payload_word  = w;
            r.word_index    = next_index;
            running_xor ^= w;
            next_index++;
            if (words_left != 0) words_left--;
            if (words_left == 0) phase = TAKE_SUM;
         end
         TAKE_SUM: begin
            if (w != running_xor) begin
               phase = HUNT_BEGIN;
               r.frame_done = 1'b1;
               r.status = ST_BAD_SUM;
            end else begin
               phase = TAKE_END;
            end
         end
         TAKE_END: begin
            r.frame_done = 1'b1;
            if (w != END_MARK) begin
               phase = HUNT_BEGIN;
               r.status = ST_NO_END;
            end else begin
               phase = WAIT_BEGIN;
               r.status = ST_OK;
               r.bit_count = frame_bits;
            end
         end
         HUNT_BEGIN: begin
            if (w == BEGIN_MARK) phase = TAKE_COUNT;
         end
         default: begin
            if (w == BEGIN_MARK) begin
               phase = TAKE_COUNT;
            end else begin
               phase = HUNT_BEGIN;
               r.frame_done = 1'b1;
               r.status = ST_NO_BEGIN;
            end
         end
      endcase
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      int taken, given;
      taken = 0;
      given = 0;
      if (reset) begin
         phase       = WAIT_BEGIN;
         frame_bits  = '0;
         words_left  = '0;
         next_index  = '0;
         running_xor = '0;
         expected_results.delete();
         pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            given = 1;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result item, expected none, actual status %h",
                        $time, rsp_status);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               compare_field("payload_valid", want.payload_valid, rsp_payload_valid);
               compare_field("payload_word", want.payload_word, rsp_payload_word);
               compare_field("word_index", want.word_index, rsp_word_index);
               compare_field("frame_done", want.frame_done, rsp_frame_done);
               compare_field("status", want.status, rsp_status);
               compare_field("bit_count", want.bit_count, rsp_bit_count);
            end
         end
         if (req_valid && !req_stall) begin
            taken = 1;
            expected_results.push_back(decode_frame_word(req_in_word));
         end
         pending <= pending + taken - given;
      end
   end

endmodule

>>> verif/testbench.sv
// Top of the frame checker testbench: clock, reset, word stream, result stalls and verdict.
`timescale 1ns / 100ps

module testbench;
   import xcfd_pkg::*;

   localparam int unsigned FRAME_BITS_MAX = 65536;

   typedef enum int {
      FLAW_NONE,
      FLAW_SUM,
      FLAW_END,
      FLAW_CUT
   } frame_flaw_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [WORD_W-1:0]   req_in_word = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_payload_valid;
   logic [WORD_W-1:0]   rsp_payload_word;
   logic [INDEX_W-1:0]  rsp_word_index;
   logic                rsp_frame_done;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_bit_count;
   int                  fail_count;
   int                  pending;
   int unsigned         words_sent = 0;
   logic                sender_calm = 1'b0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   xor_checked_frame_decoder_unit #(
      .MAX_BITS(FRAME_BITS_MAX)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_in_word(req_in_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload_valid(rsp_payload_valid),
      .rsp_payload_word(rsp_payload_word),
      .rsp_word_index(rsp_word_index),
      .rsp_frame_done(rsp_frame_done),
      .rsp_status(rsp_status),
      .rsp_bit_count(rsp_bit_count)
   );

   frame_result_checker #(
      .MAX_BITS(FRAME_BITS_MAX)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_in_word(req_in_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload_valid(rsp_payload_valid),
      .rsp_payload_word(rsp_payload_word),
      .rsp_word_index(rsp_word_index),
      .rsp_frame_done(rsp_frame_done),
      .rsp_status(rsp_status),
      .rsp_bit_count(rsp_bit_count),
      .fail_count(fail_count),
      .pending(pending)
   );

   task automatic send_word(input logic [WORD_W-1:0] w);
      int unsigned gap;
      gap = sender_calm ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_word <= w;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic send_frame(input int unsigned bits, input frame_flaw_type flaw);
      int unsigned n_words, n_sent;
      logic [WORD_W-1:0] w, sum;
      n_words = (bits + 31) / 32;
      n_sent  = (flaw == FLAW_CUT) ? $urandom_range(1, n_words - 1) : n_words;
      sum = '0;
      send_word(BEGIN_MARK);
      send_word(bits);
      for (int unsigned i = 0; i < n_sent; i++) begin
         case ($urandom_range(0, 9))
            0: w = '0;
            1: w = '1;
            default: w = $urandom();
         endcase
         sum ^= w;
         send_word(w);
      end
      if (flaw == FLAW_CUT) return;
      if (flaw == FLAW_SUM) sum ^= ($urandom() | 32'h1);
      send_word(sum);
      if (flaw == FLAW_END) begin
         do w = $urandom(); while (w == END_MARK);
         send_word(w);
      end else begin
         send_word(END_MARK);
      end
   endtask

   // receiver: random stalls, quiet stretches, and long hold-offs to back up the block
   initial begin
      int unsigned hold, results;
      logic calm;
      results = 0;
      calm = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (results == 150 || $urandom_range(0, 299) == 0) hold = $urandom_range(30, 60);
         else hold = calm ? 0 : $urandom_range(0, 4);
         if ($urandom_range(0, 24) == 0) calm = !calm;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         results++;
      end
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int unsigned pick, round;
      logic [WORD_W-1:0] w;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_word(32'h1234_5678);
      send_word(32'hDEAD_BEEF);
      send_frame(0, FLAW_NONE);
      send_word(32'h0000_0001);
      send_word(BEGIN_MARK);
      send_word(32'h8000_0000);
      send_word(BEGIN_MARK);
      send_word(FRAME_BITS_MAX + 1);
      send_word(BEGIN_MARK);
      send_word(32'hFFFF_FFFF);
      send_frame(33, FLAW_SUM);
      send_frame(32, FLAW_END);
      send_frame(1, FLAW_NONE);
      drain_results();

      round = 0;
      while (words_sent < 650) begin
         round++;
         if ($urandom_range(0, 14) == 0) sender_calm = !sender_calm;
         pick = $urandom_range(0, 99);
         if (round == 25) begin
            send_frame(FRAME_BITS_MAX / 16, FLAW_NONE);
         end else if (pick < 82) begin
            case ($urandom_range(0, 19))
               0, 1, 2: w = 32 * $urandom_range(0, 8);
               3:       w = $urandom_range(257, 4096);
               default: w = $urandom_range(0, 256);
            endcase
            if (pick < 60)      send_frame(w, FLAW_NONE);
            else if (pick < 70) send_frame(w, FLAW_SUM);
            else if (pick < 77) send_frame(w, FLAW_END);
            else                send_frame(w < 33 ? w + 64 : w, FLAW_CUT);
         end else if (pick < 90) begin
            case ($urandom_range(0, 3))
               0:       w = FRAME_BITS_MAX + 1;
               1:       w = 32'hFFFF_FFFF;
               2:       w = 32'h8000_0000 | $urandom();
               default: w = $urandom_range(FRAME_BITS_MAX + 1, 32'h7FFF_FFFF);
            endcase
            send_word(BEGIN_MARK);
            send_word(w);
         end else begin
            repeat ($urandom_range(1, 3)) begin
               case ($urandom_range(0, 5))
                  0:       send_word(BEGIN_MARK);
                  1:       send_word(END_MARK);
                  default: send_word($urandom());
               endcase
            end
         end
         if ($urandom_range(0, 11) == 0) drain_results();
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
